@@ sv/srm_pkg.sv @@
package srm_pkg;

   localparam int DIV_STEPS  = 48;
   localparam int SQRT_STEPS = 32;

   // operand index pairs of a cross product: r[k] = a*b terms 2k minus 2k+1
   localparam int CROSS_A [6] = '{1, 2, 2, 0, 0, 1};
   localparam int CROSS_B [6] = '{2, 1, 0, 2, 1, 0};

   localparam logic [47:0] T_LIMIT  = 48'h7FFF_FFFF_FFFF;
   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0][31:0] v;
      logic [2:0][15:0] d;
   } ray_type;

   typedef struct packed {
      ray_type r1;
      ray_type r2;
   } pair_type;

   typedef struct packed {
      logic [50:0] rem;
      logic [47:0] quo;
      logic [47:0] feed;
      logic        neg;
      logic        ovf;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      pair_type     pair;
      logic [50:0]  s;
      logic         par;
      div_lane_type l1;
      div_lane_type l2;
   } div_type;

   typedef struct packed {
      logic             valid;
      logic [33:0]      rem;
      logic [31:0]      root;
      logic [63:0]      x;
      logic [2:0][31:0] mid;
      logic             flag;
      logic             far;
      logic             par;
   } sqrt_type;

endpackage

@@ sv/skew_ray_midpoint.sv @@
// Closest approach of two skew rays: midpoint and distance, one transaction per cycle.
// Pipeline from start to result: 7 set-up stages, 48 divider stages, 6 stages to the
// sum of squares, 32 root stages and the output register. Throughput: one transaction
// every cycle; busy stays low.
// Reset (synchronous, active high) clears the valid bits of every stage; data is not reset.
// rsp_valid is a one-cycle strobe; the receiver cannot stall.
module skew_ray_midpoint (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_first_vertex_x,
   input  logic [31:0] req_first_vertex_y,
   input  logic [31:0] req_first_vertex_z,
   input  logic [15:0] req_first_dir_x,
   input  logic [15:0] req_first_dir_y,
   input  logic [15:0] req_first_dir_z,
   input  logic [31:0] req_second_vertex_x,
   input  logic [31:0] req_second_vertex_y,
   input  logic [31:0] req_second_vertex_z,
   input  logic [15:0] req_second_dir_x,
   input  logic [15:0] req_second_dir_y,
   input  logic [15:0] req_second_dir_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_midpoint_x,
   output logic [31:0] rsp_midpoint_y,
   output logic [31:0] rsp_midpoint_z,
   output logic [30:0] rsp_ray_distance,
   output logic        rsp_degenerate
);

   srm_pkg::pair_type pair_c;
   srm_pkg::div_type  div_bus [srm_pkg::DIV_STEPS + 1];
   srm_pkg::sqrt_type sqrt_bus [srm_pkg::SQRT_STEPS + 1];
   srm_pkg::sqrt_type last_c;

   logic              valid_ff;
   logic [2:0][31:0]  mid_in;
   logic [2:0][31:0]  mid_ff;
   logic [30:0]       dist_in;
   logic [30:0]       dist_ff;
   logic              flag_in;
   logic              flag_ff;

   // the pipeline never holds off a transaction
   assign busy = 1'b0;

   always_comb begin
      pair_c.r1.v = {req_first_vertex_z, req_first_vertex_y, req_first_vertex_x};
      pair_c.r1.d = {req_first_dir_z, req_first_dir_y, req_first_dir_x};
      pair_c.r2.v = {req_second_vertex_z, req_second_vertex_y, req_second_vertex_x};
      pair_c.r2.d = {req_second_dir_z, req_second_dir_y, req_second_dir_x};
   end

   // n = d1 x d2, s = m.m, numerators of t1/t2, divider set-up
   srm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_pair  (pair_c),
      .out_div  (div_bus[0])
   );

   // 48-bit quotient, one bit per stage, both parameters side by side
   for (genvar g = 0; g < srm_pkg::DIV_STEPS; g++) begin : g_div
      srm_div_stage u_div (
         .clock (clock),
         .reset (reset),
         .din   (div_bus[g]),
         .dout  (div_bus[g+1])
      );
   end

   // points on the rays, midpoint, squared distance
   srm_back u_back (
      .clock (clock),
      .reset (reset),
      .din   (div_bus[srm_pkg::DIV_STEPS]),
      .dout  (sqrt_bus[0])
   );

   // 32-bit integer square root, one bit per stage
   for (genvar g = 0; g < srm_pkg::SQRT_STEPS; g++) begin : g_sqrt
      srm_sqrt_stage u_sqrt (
         .clock (clock),
         .reset (reset),
         .din   (sqrt_bus[g]),
         .dout  (sqrt_bus[g+1])
      );
   end

   assign last_c = sqrt_bus[srm_pkg::SQRT_STEPS];

   // final clamp; parallel rays give zeros with the flag raised
   always_comb begin
      if (last_c.par) begin
         mid_in  = '0;
         dist_in = '0;
         flag_in = 1'b1;
      end else if (last_c.far || last_c.root[31]) begin
         mid_in  = last_c.mid;
         dist_in = srm_pkg::DIST_MAX;
         flag_in = 1'b1;
      end else begin
         mid_in  = last_c.mid;
         dist_in = last_c.root[30:0];
         flag_in = last_c.flag;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff  <= mid_in;
      dist_ff <= dist_in;
      flag_ff <= flag_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last_c.valid;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_midpoint_x   = mid_ff[0];
   assign rsp_midpoint_y   = mid_ff[1];
   assign rsp_midpoint_z   = mid_ff[2];
   assign rsp_ray_distance = dist_ff;
   assign rsp_degenerate   = flag_ff;

endmodule

@@ sv/srm_front.sv @@
module srm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  srm_pkg::pair_type in_pair,
   output srm_pkg::div_type  out_div
);

   logic [5:0]        valid_ff;
   srm_pkg::pair_type pair_ff [6];

   // F1: direction products, vertex difference
   logic signed [31:0] nd_in [6];
   logic signed [31:0] nd_ff [6];
   logic signed [32:0] w_in [3];
   logic signed [32:0] w_ff [3];
   // F2: scaled normal, w x d products
   logic signed [32:0] n_c [3];
   logic signed [24:0] m_in [3];
   logic signed [24:0] m_ff [3];
   logic signed [48:0] wd1_in [6];
   logic signed [48:0] wd2_in [6];
   logic signed [48:0] wd1_ff [6];
   logic signed [48:0] wd2_ff [6];
   // F3: squares, cross terms
   logic signed [49:0] msq_in [3];
   logic signed [49:0] msq_ff [3];
   logic signed [49:0] cd1_c [3];
   logic signed [49:0] cd2_c [3];
   logic signed [35:0] c1_in [3];
   logic signed [35:0] c2_in [3];
   logic signed [35:0] c1_ff [3];
   logic signed [35:0] c2_ff [3];
   logic signed [24:0] m3_ff [3];
   // F4: s, dot products
   logic [50:0]        s4_in;
   logic [50:0]        s4_ff;
   logic signed [60:0] mc1_in [3];
   logic signed [60:0] mc2_in [3];
   logic signed [60:0] mc1_ff [3];
   logic signed [60:0] mc2_ff [3];
   // F5: numerators
   logic signed [62:0] num1_in;
   logic signed [62:0] num2_in;
   logic signed [62:0] num1_ff;
   logic signed [62:0] num2_ff;
   logic [50:0]        s5_ff;
   // F6: magnitudes
   logic [62:0]        mag1_in;
   logic [62:0]        mag2_in;
   logic [62:0]        mag1_ff;
   logic [62:0]        mag2_ff;
   logic               neg1_ff;
   logic               neg2_ff;
   logic [50:0]        s6_ff;
   logic               par6_ff;
   // F7: divider set-up
   srm_pkg::div_type   div_in;
   srm_pkg::div_type   div_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         nd_in[k] = $signed(in_pair.r1.d[srm_pkg::CROSS_A[k]])
                  * $signed(in_pair.r2.d[srm_pkg::CROSS_B[k]]);
         wd2_in[k] = w_ff[srm_pkg::CROSS_A[k]]
                   * $signed(pair_ff[0].r2.d[srm_pkg::CROSS_B[k]]);
         wd1_in[k] = w_ff[srm_pkg::CROSS_A[k]]
                   * $signed(pair_ff[0].r1.d[srm_pkg::CROSS_B[k]]);
      end
      for (int i = 0; i < 3; i++) begin
         w_in[i]   = 33'($signed(in_pair.r2.v[i])) - 33'($signed(in_pair.r1.v[i]));
         n_c[i]    = 33'(nd_ff[2*i]) - 33'(nd_ff[2*i+1]);
         m_in[i]   = 25'(n_c[i] >>> 8);
         msq_in[i] = m_ff[i] * m_ff[i];
         cd1_c[i]  = 50'(wd1_ff[2*i]) - 50'(wd1_ff[2*i+1]);
         cd2_c[i]  = 50'(wd2_ff[2*i]) - 50'(wd2_ff[2*i+1]);
         c1_in[i]  = 36'(cd1_c[i] >>> 14);
         c2_in[i]  = 36'(cd2_c[i] >>> 14);
         mc1_in[i] = m3_ff[i] * c1_ff[i];
         mc2_in[i] = m3_ff[i] * c2_ff[i];
      end
      s4_in = 51'($unsigned(msq_ff[0])) + 51'($unsigned(msq_ff[1]))
            + 51'($unsigned(msq_ff[2]));
      num1_in = 63'(mc1_ff[0]) + 63'(mc1_ff[1]) + 63'(mc1_ff[2]);
      num2_in = 63'(mc2_ff[0]) + 63'(mc2_ff[1]) + 63'(mc2_ff[2]);
      mag1_in = num1_ff[62] ? 63'(-num1_ff) : 63'(num1_ff);
      mag2_in = num2_ff[62] ? 63'(-num2_ff) : 63'(num2_ff);

      // t2 uses w x d1, t1 uses w x d2
      div_in.valid   = valid_ff[5];
      div_in.pair    = pair_ff[5];
      div_in.s       = s6_ff;
      div_in.par     = par6_ff;
      div_in.l1.rem  = 51'(mag2_ff[62:28]);
      div_in.l1.feed = {mag2_ff[27:0], 20'b0};
      div_in.l1.quo  = '0;
      div_in.l1.neg  = neg2_ff;
      div_in.l1.ovf  = ({16'b0, mag2_ff} >= {s6_ff, 28'b0});
      div_in.l2.rem  = 51'(mag1_ff[62:28]);
      div_in.l2.feed = {mag1_ff[27:0], 20'b0};
      div_in.l2.quo  = '0;
      div_in.l2.neg  = neg1_ff;
      div_in.l2.ovf  = ({16'b0, mag1_ff} >= {s6_ff, 28'b0});
   end

   always_ff @(posedge clock) begin
      pair_ff[0] <= in_pair;
      for (int k = 1; k < 6; k++) begin
         pair_ff[k] <= pair_ff[k-1];
      end
      for (int k = 0; k < 6; k++) begin
         nd_ff[k]  <= nd_in[k];
         wd1_ff[k] <= wd1_in[k];
         wd2_ff[k] <= wd2_in[k];
      end
      for (int i = 0; i < 3; i++) begin
         w_ff[i]   <= w_in[i];
         m_ff[i]   <= m_in[i];
         msq_ff[i] <= msq_in[i];
         c1_ff[i]  <= c1_in[i];
         c2_ff[i]  <= c2_in[i];
         m3_ff[i]  <= m_ff[i];
         mc1_ff[i] <= mc1_in[i];
         mc2_ff[i] <= mc2_in[i];
      end
      s4_ff   <= s4_in;
      num1_ff <= num1_in;
      num2_ff <= num2_in;
      s5_ff   <= s4_ff;
      mag1_ff <= mag1_in;
      mag2_ff <= mag2_in;
      neg1_ff <= num1_ff[62];
      neg2_ff <= num2_ff[62];
      s6_ff   <= s5_ff;
      par6_ff <= (s5_ff == '0);
      if (reset) begin
         valid_ff     <= '0;
         div_ff.valid <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
         div_ff   <= div_in;
      end
   end

   assign out_div = div_ff;

endmodule

@@ sv/srm_div_stage.sv @@
module srm_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  srm_pkg::div_type din,
   output srm_pkg::div_type dout
);

   srm_pkg::div_type dout_in;
   srm_pkg::div_type dout_ff;

   // one restoring quotient bit per lane
   function automatic srm_pkg::div_lane_type div_step(srm_pkg::div_lane_type l,
                                                      logic [50:0] s);
      srm_pkg::div_lane_type r;
      logic [51:0]           cat;
      logic                  ge;
      cat    = {l.rem, l.feed[47]};
      ge     = (cat >= {1'b0, s});
      r      = l;
      r.rem  = ge ? 51'(cat - {1'b0, s}) : 51'(cat);
      r.quo  = {l.quo[46:0], ge};
      r.feed = {l.feed[46:0], 1'b0};
      return r;
   endfunction

   always_comb begin
      dout_in    = din;
      dout_in.l1 = div_step(din.l1, din.s);
      dout_in.l2 = div_step(din.l2, din.s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

@@ sv/srm_back.sv @@
module srm_back (
   input  logic              clock,
   input  logic              reset,
   input  srm_pkg::div_type  din,
   output srm_pkg::sqrt_type dout
);

   logic [4:0]         valid_ff;
   srm_pkg::pair_type  pair_ff [2];
   logic               par_ff [5];
   logic               flag_ff [5];

   // B1: signed, saturated parameters
   logic [47:0]        tm1_c;
   logic [47:0]        tm2_c;
   logic               sat_c;
   logic signed [48:0] t1_in;
   logic signed [48:0] t2_in;
   logic signed [48:0] t1_ff;
   logic signed [48:0] t2_ff;
   // B2: offsets along the rays
   logic signed [64:0] e1_in [3];
   logic signed [64:0] e2_in [3];
   logic signed [64:0] e1_ff [3];
   logic signed [64:0] e2_ff [3];
   // B3: closest points
   logic signed [51:0] p1_in [3];
   logic signed [51:0] p2_in [3];
   logic signed [51:0] p1_ff [3];
   logic signed [51:0] p2_ff [3];
   // B4: midpoint, difference
   logic signed [52:0] sm_c [3];
   logic signed [51:0] md_c [3];
   logic signed [52:0] df_c [3];
   logic [2:0][31:0]   mid_in;
   logic [2:0][31:0]   mid_ff [2];
   logic [31:0]        ad_in [3];
   logic [31:0]        ad_ff [3];
   logic               clip_c;
   logic               far_in;
   logic               far_ff [2];
   // B5, B6: squares, sum
   logic [63:0]        sq_ff [3];
   srm_pkg::sqrt_type  sq_out;
   srm_pkg::sqrt_type  out_ff;

   always_comb begin
      tm1_c = (din.l1.ovf | din.l1.quo[47]) ? srm_pkg::T_LIMIT : din.l1.quo;
      tm2_c = (din.l2.ovf | din.l2.quo[47]) ? srm_pkg::T_LIMIT : din.l2.quo;
      sat_c = din.l1.ovf | din.l1.quo[47] | din.l2.ovf | din.l2.quo[47];
      // lane 1 carries t1, lane 2 carries t2
      t1_in = din.l1.neg ? -$signed({1'b0, tm1_c}) : $signed({1'b0, tm1_c});
      t2_in = din.l2.neg ? -$signed({1'b0, tm2_c}) : $signed({1'b0, tm2_c});

      clip_c = 1'b0;
      far_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = t1_ff * $signed(pair_ff[0].r1.d[i]);
         e2_in[i] = t2_ff * $signed(pair_ff[0].r2.d[i]);
         p1_in[i] = 52'($signed(pair_ff[1].r1.v[i])) + 52'(e1_ff[i] >>> 14);
         p2_in[i] = 52'($signed(pair_ff[1].r2.v[i])) + 52'(e2_ff[i] >>> 14);
         sm_c[i]  = 53'(p1_ff[i]) + 53'(p2_ff[i]);
         md_c[i]  = 52'(sm_c[i] >>> 1);
         df_c[i]  = 53'(p1_ff[i]) - 53'(p2_ff[i]);
         if (md_c[i] > 52'sh7FFF_FFFF) begin
            mid_in[i] = 32'h7FFF_FFFF;
            clip_c    = 1'b1;
         end else if (md_c[i] < -52'sh8000_0000) begin
            mid_in[i] = 32'h8000_0000;
            clip_c    = 1'b1;
         end else begin
            mid_in[i] = md_c[i][31:0];
         end
         if (df_c[i] > 53'sh8000_0000 || df_c[i] < -53'sh8000_0000) begin
            far_in = 1'b1;
         end
         ad_in[i] = df_c[i][52] ? 32'(-df_c[i]) : 32'(df_c[i]);
      end

      sq_out.valid = valid_ff[4];
      sq_out.rem   = '0;
      sq_out.root  = '0;
      sq_out.x     = sq_ff[0] + sq_ff[1] + sq_ff[2];
      sq_out.mid   = mid_ff[1];
      sq_out.flag  = flag_ff[4];
      sq_out.far   = far_ff[1];
      sq_out.par   = par_ff[4];
   end

   always_ff @(posedge clock) begin
      pair_ff[0] <= din.pair;
      pair_ff[1] <= pair_ff[0];
      par_ff[0]  <= din.par;
      flag_ff[0] <= sat_c;
      for (int k = 1; k < 5; k++) begin
         par_ff[k] <= par_ff[k-1];
      end
      flag_ff[1] <= flag_ff[0];
      flag_ff[2] <= flag_ff[1];
      flag_ff[3] <= flag_ff[2] | clip_c | far_in;
      flag_ff[4] <= flag_ff[3];
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      for (int i = 0; i < 3; i++) begin
         e1_ff[i] <= e1_in[i];
         e2_ff[i] <= e2_in[i];
         p1_ff[i] <= p1_in[i];
         p2_ff[i] <= p2_in[i];
         ad_ff[i] <= ad_in[i];
         sq_ff[i] <= ad_ff[i] * ad_ff[i];
      end
      mid_ff[0] <= mid_in;
      mid_ff[1] <= mid_ff[0];
      far_ff[0] <= far_in;
      far_ff[1] <= far_ff[0];
      if (reset) begin
         valid_ff     <= '0;
         out_ff.valid <= 1'b0;
      end else begin
         valid_ff <= {valid_ff[3:0], din.valid};
         out_ff   <= sq_out;
      end
   end

   assign dout = out_ff;

endmodule

@@ sv/srm_sqrt_stage.sv @@
module srm_sqrt_stage (
   input  logic              clock,
   input  logic              reset,
   input  srm_pkg::sqrt_type din,
   output srm_pkg::sqrt_type dout
);

   srm_pkg::sqrt_type dout_in;
   srm_pkg::sqrt_type dout_ff;
   logic [35:0]       cat_c;
   logic [35:0]       trial_c;
   logic              ge_c;

   // one root bit per stage, two radicand bits shifted in
   always_comb begin
      cat_c        = {din.rem, din.x[63:62]};
      trial_c      = {2'b00, din.root, 2'b01};
      ge_c         = (cat_c >= trial_c);
      dout_in      = din;
      dout_in.rem  = ge_c ? 34'(cat_c - trial_c) : 34'(cat_c);
      dout_in.root = {din.root[30:0], ge_c};
      dout_in.x    = {din.x[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

@@ tb/skew_ray_midpoint_test.sv @@
`timescale 1ns / 1ps

module skew_ray_midpoint_test;

   // expected outcome of one ray-pair transaction
   typedef struct {
      logic [31:0] mid_x;
      logic [31:0] mid_y;
      logic [31:0] mid_z;
      logic [30:0] gap;
      logic        degen;
   } approach_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   srm_pkg::pair_type drive_pair = '0;
   logic              rsp_valid;
   logic [31:0]       rsp_midpoint_x, rsp_midpoint_y, rsp_midpoint_z;
   logic [30:0]       rsp_ray_distance;
   logic              rsp_degenerate;

   approach_type      pending_approaches[$];
   int                fail_count = 0;
   bit                idling_on  = 1'b1;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   skew_ray_midpoint u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_first_vertex_x  (drive_pair.r1.v[0]),
      .req_first_vertex_y  (drive_pair.r1.v[1]),
      .req_first_vertex_z  (drive_pair.r1.v[2]),
      .req_first_dir_x     (drive_pair.r1.d[0]),
      .req_first_dir_y     (drive_pair.r1.d[1]),
      .req_first_dir_z     (drive_pair.r1.d[2]),
      .req_second_vertex_x (drive_pair.r2.v[0]),
      .req_second_vertex_y (drive_pair.r2.v[1]),
      .req_second_vertex_z (drive_pair.r2.v[2]),
      .req_second_dir_x    (drive_pair.r2.d[0]),
      .req_second_dir_y    (drive_pair.r2.d[1]),
      .req_second_dir_z    (drive_pair.r2.d[2]),
      .rsp_valid           (rsp_valid),
      .rsp_midpoint_x      (rsp_midpoint_x),
      .rsp_midpoint_y      (rsp_midpoint_y),
      .rsp_midpoint_z      (rsp_midpoint_z),
      .rsp_ray_distance    (rsp_ray_distance),
      .rsp_degenerate      (rsp_degenerate)
   );

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // signed cross product, component k
   function automatic longint cross_k(input longint a[3], input longint b[3], input int k);
      case (k)
         0:       return a[1] * b[2] - a[2] * b[1];
         1:       return a[2] * b[0] - a[0] * b[2];
         default: return a[0] * b[1] - a[1] * b[0];
      endcase
   endfunction

   // line parameter t (integer, Q.0) by restoring division, saturated at T_LIMIT
   function automatic longint line_param(input longint m[3], input longint w[3],
                                         input longint d[3], input longint unsigned s,
                                         inout bit sat);
      longint            num;
      longint unsigned   mag, quo, rem, lim;
      bit                neg;
      num = 0;
      lim = srm_pkg::T_LIMIT;
      for (int k = 0; k < 3; k++)
         num += m[k] * (cross_k(w, d, k) >>> 14);
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      quo = mag / s;
      rem = mag % s;
      if (quo > lim) begin
         quo = lim;
         sat = 1'b1;
      end else begin
         for (int i = 0; i < 20; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= s) begin
               rem = rem - s;
               quo = quo | 64'd1;
            end
            if (quo > lim) begin
               quo = lim;
               sat = 1'b1;
               break;
            end
         end
      end
      return neg ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic approach_type closest_approach(input srm_pkg::pair_type p);
      longint            v1[3], d1[3], v2[3], d2[3], w[3], m[3];
      longint            p1[3], p2[3], diff[3], mids[3], t1, t2;
      longint unsigned   s, sumsq, span;
      bit                flag, far;
      approach_type      e;
      flag = 1'b0;
      far  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         v1[k] = longint'($signed(p.r1.v[k]));
         d1[k] = longint'($signed(p.r1.d[k]));
         v2[k] = longint'($signed(p.r2.v[k]));
         d2[k] = longint'($signed(p.r2.d[k]));
         w[k]  = v2[k] - v1[k];
      end
      s = 0;
      for (int k = 0; k < 3; k++) begin
         m[k] = cross_k(d1, d2, k) >>> 8;
         s    = s + longint'(m[k] * m[k]);
      end
      if (s == 0) begin
         e = '{32'd0, 32'd0, 32'd0, 31'd0, 1'b1};
         return e;
      end
      t1 = line_param(m, w, d2, s, flag);
      t2 = line_param(m, w, d1, s, flag);
      for (int k = 0; k < 3; k++) begin
         p1[k]   = v1[k] + ((t1 * d1[k]) >>> 14);
         p2[k]   = v2[k] + ((t2 * d2[k]) >>> 14);
         mids[k] = (p1[k] + p2[k]) >>> 1;
         if (mids[k] > 64'sd2147483647) begin
            mids[k] = 64'sd2147483647;
            flag    = 1'b1;
         end else if (mids[k] < -64'sd2147483648) begin
            mids[k] = -64'sd2147483648;
            flag    = 1'b1;
         end
         diff[k] = p1[k] - p2[k];
         if (diff[k] > 64'sd2147483648 || diff[k] < -64'sd2147483648) far = 1'b1;
      end
      if (far) begin
         span = srm_pkg::DIST_MAX;
         flag = 1'b1;
      end else begin
         sumsq = 0;
         for (int k = 0; k < 3; k++) sumsq = sumsq + longint'(diff[k] * diff[k]);
         span = floor_root(sumsq);
         if (span > srm_pkg::DIST_MAX) begin
            span = srm_pkg::DIST_MAX;
            flag = 1'b1;
         end
      end
      e.mid_x = mids[0][31:0];
      e.mid_y = mids[1][31:0];
      e.mid_z = mids[2][31:0];
      e.gap   = span[30:0];
      e.degen = flag;
      return e;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // drive one pair, hold until taken; start stays high for the next one
   task automatic send_pair(input srm_pkg::pair_type p);
      bit taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (idling_on && $urandom_range(99) < 11) begin
            start = 1'b0;
         end else begin
            drive_pair = p;
            start      = 1'b1;
            @(posedge clock);
            if (!busy) begin
               pending_approaches.push_back(closest_approach(p));
               taken = 1'b1;
            end
         end
      end
   endtask

   task automatic go_quiet();
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic logic [15:0] unit_comp();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [31:0] vertex_in(input int bits);
      logic [31:0] raw;
      raw = $urandom;
      if (bits >= 32) return raw;
      return 32'($signed(raw) >>> (32 - bits));
   endfunction

   function automatic srm_pkg::pair_type random_pair();
      srm_pkg::pair_type p;
      int                vb, sel;
      sel = $urandom_range(99);
      vb  = (sel < 10) ? 32 : $urandom_range(8, 26);
      for (int k = 0; k < 3; k++) begin
         p.r1.v[k] = vertex_in(vb);
         p.r2.v[k] = vertex_in(vb);
         // a few fully random directions, mostly in the unit range
         p.r1.d[k] = (sel % 7 == 0) ? 16'($urandom) : unit_comp();
         p.r2.d[k] = (sel % 11 == 0) ? 16'($urandom) : unit_comp();
      end
      // near-parallel and parallel pairs now and then
      if (sel >= 90) begin
         for (int k = 0; k < 3; k++)
            p.r2.d[k] = (sel >= 95) ? -p.r1.d[k] : p.r1.d[k] + 16'($urandom_range(2));
      end
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   task automatic test_extremes();
      srm_pkg::pair_type p;
      // orthogonal unit axes at the origin
      p = '0;
      p.r1.d[0] = 16'sd16384;  p.r2.d[1] = 16'sd16384;
      send_pair(p);
      p.r2.v[2] = 32'h0001_0000;
      send_pair(p);
      // vertices at the ends of the range
      p.r1.v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      p.r2.v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      send_pair(p);
      p.r1.v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      p.r2.v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      send_pair(p);
      // direction fields at their full 16-bit extremes
      p.r1.d = '{16'h8000, 16'h7FFF, 16'h8000};
      p.r2.d = '{16'h7FFF, 16'h8000, 16'h8000};
      send_pair(p);
      p.r1.d = '{16'hFFFF, 16'h0001, 16'h7FFF};
      p.r2.d = '{16'h0001, 16'hFFFF, 16'h8000};
      p.r1.v = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
      send_pair(p);
      p.r1.d = '{-16'sd16384, 16'sd0, 16'sd0};
      p.r2.d = '{16'sd0, 16'sd0, -16'sd16384};
      send_pair(p);
      go_quiet();
   endtask

   task automatic test_parallel();
      srm_pkg::pair_type p;
      p = '0;
      // identical directions
      p.r1.d = '{16'sd16384, 16'sd0, 16'sd0};
      p.r2.d = p.r1.d;
      p.r2.v[1] = 32'h0003_0000;
      send_pair(p);
      // opposite directions
      p.r2.d = '{-16'sd16384, 16'sd0, 16'sd0};
      send_pair(p);
      // all-zero directions
      p.r1.d = '0;
      p.r2.d = '0;
      send_pair(p);
      // cross product nonzero: below the normalising shift, then above it
      p.r1.d = '{16'sd1, 16'sd0, 16'sd0};
      p.r2.d = '{16'sd0, 16'sd1, 16'sd0};
      send_pair(p);
      p.r1.d = '{16'sd16384, 16'sd0, 16'sd0};
      p.r2.d = '{16'sd16384, 16'sd1, 16'sd0};
      send_pair(p);
      go_quiet();
   endtask

   task automatic test_saturation();
      srm_pkg::pair_type p;
      // nearly parallel with distant vertices: huge parameter
      p = '0;
      p.r1.d = '{16'sd16384, 16'sd0, 16'sd0};
      p.r2.d = '{16'sd16384, 16'sd16, 16'sd0};
      p.r1.v = '{32'h8000_0000, 32'h8000_0000, 32'h0};
      p.r2.v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      send_pair(p);
      p.r2.d = '{16'sd16384, -16'sd256, 16'sd0};
      send_pair(p);
      // midpoint clamp and distance clamp
      p.r1.d = '{16'sd0, 16'sd16384, 16'sd0};
      p.r2.d = '{16'sd0, 16'sd0, 16'sd16384};
      p.r1.v = '{32'h7FFF_0000, 32'h0, 32'h0};
      p.r2.v = '{32'h7FFF_0000, 32'h0, 32'h0};
      send_pair(p);
      p.r1.v = '{32'h8000_0000, 32'h0, 32'h0};
      p.r2.v = '{32'h7FFF_FFFF, 32'h0, 32'h0};
      send_pair(p);
      p.r1.v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      p.r2.v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      p.r1.d = '{16'h7FFF, 16'h7FFF, 16'h8000};
      p.r2.d = '{16'h8000, 16'h7FFF, 16'h7FFF};
      send_pair(p);
      go_quiet();
   endtask

   task automatic test_random(input int count, input bit with_idles);
      idling_on = with_idles;
      for (int i = 0; i < count; i++) send_pair(random_pair());
      go_quiet();
      idling_on = 1'b1;
   endtask

   // sender holds off until the pipeline has drained completely
   task automatic test_drain_pause();
      test_random(20, 1'b1);
      wait (pending_approaches.size() == 0);
      test_random(20, 1'b1);
   endtask

   // ---------------------------------------------------------------
   // Result checker: every strobe must match the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      approach_type e;
      if (!reset && rsp_valid) begin
         if (pending_approaches.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            e = pending_approaches.pop_front();
            if (rsp_midpoint_x !== e.mid_x) begin
               $error("midpoint_x exp %h got %h", e.mid_x, rsp_midpoint_x);
               fail_count++;
            end
            if (rsp_midpoint_y !== e.mid_y) begin
               $error("midpoint_y exp %h got %h", e.mid_y, rsp_midpoint_y);
               fail_count++;
            end
            if (rsp_midpoint_z !== e.mid_z) begin
               $error("midpoint_z exp %h got %h", e.mid_z, rsp_midpoint_z);
               fail_count++;
            end
            if (rsp_ray_distance !== e.gap) begin
               $error("ray_distance exp %h got %h", e.gap, rsp_ray_distance);
               fail_count++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate exp %b got %b", e.degen, rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

   // run-away guard
   initial begin
      #5ms;
      $display("** skew_ray_midpoint: FAILED **");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_parallel();
      test_saturation();
      test_random(150, 1'b1);
      test_random(100, 1'b0);     // back-to-back stretch
      test_drain_pause();
      test_random(160, 1'b1);
      wait (pending_approaches.size() == 0);
      repeat (120) @(posedge clock);
      if (fail_count == 0) begin
         $display("** skew_ray_midpoint: PASSED **");
      end else begin
         $display("** skew_ray_midpoint: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/srm_pkg.sv
sv/srm_front.sv
sv/srm_div_stage.sv
sv/srm_back.sv
sv/srm_sqrt_stage.sv
sv/skew_ray_midpoint.sv
tb/skew_ray_midpoint_test.sv
